// ===== hdl/ssrt_pkg.sv =====
// Package for the sorted sector range table: types, codes and constants.
package ssrt_pkg;
   localparam int TABLE_DEPTH_DEFAULT = 16;

   localparam logic [2:0] ACT_INSERT   = 3'd0;
   localparam logic [2:0] ACT_FIND     = 3'd1;
   localparam logic [2:0] ACT_REMOVE   = 3'd2;
   localparam logic [2:0] ACT_CLIP     = 3'd3;
   localparam logic [2:0] ACT_TRUNCATE = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [31:0] start;
      logic [15:0] length;
      logic [7:0]  id;
      logic        enabled;
   } entry_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] sector;
      logic [15:0] count;
      logic [7:0]  req_id;
      logic [31:0] total_sectors;
      logic [31:0] limit_sectors;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  found_id;
      logic        found_enabled;
      logic [31:0] clip_start;
      logic [15:0] clip_count;
      logic        any_disabled;
   } rsp_type;
endpackage

// ===== hdl/ssrt_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface ssrt_req_if;
   logic                 valid;
   logic                 ready;
   ssrt_pkg::req_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ssrt_rsp_if;
   logic                 valid;
   logic                 ready;
   ssrt_pkg::rsp_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/ssrt_cell.sv =====
// One table cell: holds an entry and hands it on to the next cell when rotating.
module ssrt_cell (
   input  logic                clock,
   input  logic                rotate,
   input  ssrt_pkg::entry_type prev_entry,
   output ssrt_pkg::entry_type entry
);
   ssrt_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (rotate) begin
         entry_ff <= prev_entry;
      end
   end

   assign entry = entry_ff;
endmodule

// ===== hdl/ssrt_ctrl.sv =====
// Sequencer: rotates the ring of cells through one pass per request and works on the head.
module ssrt_ctrl #(
   parameter int TABLE_DEPTH = ssrt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   ssrt_req_if.sink            req,
   ssrt_rsp_if.source          rsp,
   input  ssrt_pkg::entry_type tail_entry,
   input  ssrt_pkg::entry_type carry_entry,
   output ssrt_pkg::entry_type head_in,
   output logic                rotate
);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0]          state_ff, state_in;
   ssrt_pkg::req_type   req_ff;
   ssrt_pkg::rsp_type   rsp_ff, rsp_in;
   logic [CW-1:0]       count_ff, count_in;   // valid entries
   logic [CW-1:0]       step_ff, step_in;     // ring steps done this pass
   logic                done_ff, done_in;     // insert placed / find or remove hit / clip stopped
   logic signed [33:0]  cstart_ff, cstart_in;
   logic signed [33:0]  ccnt_ff, ccnt_in;

   logic [32:0] tail_end;
   logic        real_entry;
   logic        full;
   logic [CW-1:0] last_step;
   logic signed [33:0] t_start, t_end;

   assign tail_end   = {1'b0, tail_entry.start} + {17'd0, tail_entry.length};
   assign real_entry = (step_ff < count_ff);
   assign full       = (count_ff >= DEPTH_C);
   assign t_start    = {2'b00, tail_entry.start};
   assign t_end      = {1'b0, tail_end};
   // a remove pass takes one extra step: entries land one cell late through the carry
   assign last_step  = (req_ff.action == ssrt_pkg::ACT_REMOVE) ? DEPTH_C : DEPTH_C - 1'b1;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = rsp_ff;

   // Entry k sits at the tail on step k; whatever is fed to the head on step k
   // ends up as entry k after the pass (entry k - 1 on a remove pass).
   always_comb begin
      state_in  = state_ff;
      rsp_in    = rsp_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      done_in   = done_ff;
      cstart_in = cstart_ff;
      ccnt_in   = ccnt_ff;
      head_in   = tail_entry;
      rotate    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_RUN;
               step_in  = '0;
               done_in  = 1'b0;
               rsp_in   = '0;
               ccnt_in  = (req.data.count == 16'd0) ? 34'sd1 : $signed({18'd0, req.data.count});
               if (req.data.total_sectors == 32'd0) begin
                  cstart_in = '0;
               end else if (req.data.sector >= req.data.total_sectors) begin
                  cstart_in = $signed({2'b00, req.data.total_sectors - 32'd1});
               end else begin
                  cstart_in = $signed({2'b00, req.data.sector});
               end
            end
         end
         S_RUN: begin
            rotate  = 1'b1;
            step_in = step_ff + 1'b1;
            case (req_ff.action)
               ssrt_pkg::ACT_INSERT: begin
                  // before the slot straight through, then the new entry,
                  // then one step late through the carry stage
                  if (!full) begin
                     if (done_ff) begin
                        head_in = carry_entry;
                     end else if (!real_entry || tail_entry.start > req_ff.sector) begin
                        head_in.start   = req_ff.sector;
                        head_in.length  = req_ff.count;
                        head_in.id      = req_ff.req_id;
                        head_in.enabled = 1'b1;
                        done_in = 1'b1;
                     end
                  end
               end
               ssrt_pkg::ACT_FIND: begin
                  if (real_entry && !done_ff && tail_entry.start <= req_ff.sector &&
                      tail_end > {1'b0, req_ff.sector}) begin
                     done_in = 1'b1;
                     rsp_in.found_id      = tail_entry.id;
                     rsp_in.found_enabled = tail_entry.enabled;
                  end
               end
               ssrt_pkg::ACT_REMOVE: begin
                  // through the carry up to the match, straight from the tail after it
                  if (!done_ff) begin
                     head_in = carry_entry;
                     if (real_entry && tail_entry.id == req_ff.req_id) done_in = 1'b1;
                  end
               end
               ssrt_pkg::ACT_CLIP: begin
                  if (real_entry && !done_ff && ccnt_ff > 0 && tail_entry.enabled) begin
                     if (t_start > cstart_ff) begin
                        if (t_start - cstart_ff < ccnt_ff) ccnt_in = t_start - cstart_ff;
                        done_in = 1'b1;
                     end else if (t_end > cstart_ff) begin
                        ccnt_in   = cstart_ff + ccnt_ff - t_end;
                        cstart_in = t_end;
                     end
                  end
               end
               ssrt_pkg::ACT_TRUNCATE: begin
                  if (real_entry && tail_end > {1'b0, req_ff.limit_sectors}) begin
                     head_in.enabled     = 1'b0;
                     rsp_in.any_disabled = 1'b1;
                  end
               end
               default: ;
            endcase
            if (step_ff == last_step) begin
               state_in = S_OUT;
               unique case (req_ff.action)
                  ssrt_pkg::ACT_INSERT: begin
                     if (full) rsp_in.status = ssrt_pkg::ST_FULL;
                     else count_in = count_ff + 1'b1;
                  end
                  ssrt_pkg::ACT_FIND:
                     if (!done_in) rsp_in.status = ssrt_pkg::ST_NOT_FOUND;
                  ssrt_pkg::ACT_REMOVE: begin
                     if (done_in) count_in = count_ff - 1'b1;
                     else rsp_in.status = ssrt_pkg::ST_NOT_FOUND;
                  end
                  ssrt_pkg::ACT_CLIP: begin
                     if (cstart_in > 34'sh0_FFFF_FFFF) begin
                        rsp_in.clip_start = 32'hFFFF_FFFF;
                        rsp_in.clip_count = '0;
                     end else begin
                        rsp_in.clip_start = cstart_in[31:0];
                        rsp_in.clip_count = (ccnt_in < 0) ? 16'd0 : ccnt_in[15:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      if (state_ff == S_IDLE && req.valid) req_ff <= req.data;
      rsp_ff    <= rsp_in;
      step_ff   <= step_in;
      done_ff   <= done_in;
      cstart_ff <= cstart_in;
      ccnt_ff   <= ccnt_in;
   end
endmodule

// ===== hdl/ssrt_remover.sv =====
// Carry stage: holds the entry that left the ring tail on the previous step.
module ssrt_remover (
   input  logic                clock,
   input  logic                rotate,
   input  ssrt_pkg::entry_type in_entry,
   output ssrt_pkg::entry_type out_entry
);
   ssrt_pkg::entry_type hold_ff;

   always_ff @(posedge clock) begin
      if (rotate) hold_ff <= in_entry;
   end

   assign out_entry = hold_ff;
endmodule

// ===== hdl/sorted_sector_range_table_top.sv =====
// Top level of the sorted sector range table: ring of entry cells and sequencer.
// The response is offered after one full pass of the ring that follows the request
// transfer; a remove pass takes one extra ring step.
// A new request is taken only once the previous response has been accepted, so a
// held-off response also holds off the next request.
// Reset: synchronous, clears the entry count and the sequencer; cell contents stay.
module sorted_sector_range_table_top #(
   parameter int TABLE_DEPTH = ssrt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ssrt_req_if.sink   req,
   ssrt_rsp_if.source rsp
);
   ssrt_pkg::entry_type chain [TABLE_DEPTH+1];
   ssrt_pkg::entry_type head_in;
   ssrt_pkg::entry_type carry_entry;
   logic                rotate;

   // chain[0] is fed by the sequencer; the last cell's entry returns to it
   assign chain[0] = head_in;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      ssrt_cell u_cell (
         .clock      (clock),
         .rotate     (rotate),
         .prev_entry (chain[g]),
         .entry      (chain[g+1])
      );
   end

   // one-step delay of the tail: lets insert and remove shift entries by one cell
   ssrt_remover u_carry (
      .clock     (clock),
      .rotate    (rotate),
      .in_entry  (chain[TABLE_DEPTH]),
      .out_entry (carry_entry)
   );

   ssrt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .tail_entry  (chain[TABLE_DEPTH]),
      .carry_entry (carry_entry),
      .head_in     (head_in),
      .rotate      (rotate)
   );
endmodule

// ===== verif/sorted_sector_range_table_top_tb.sv =====
// Testbench for the sorted sector range table: directed and random actions against a predictor.
`timescale 1ns / 1ps

module sorted_sector_range_table_top_tb;
   localparam int DEPTH      = ssrt_pkg::TABLE_DEPTH_DEFAULT;
   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;

   ssrt_req_if req_ch ();
   ssrt_rsp_if rsp_ch ();

   sorted_sector_range_table_top #(.TABLE_DEPTH(DEPTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // 12 ns period
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // predictor's copy of the table
   ssrt_pkg::entry_type  tbl [DEPTH];
   int                   tbl_count = 0;
   ssrt_pkg::rsp_type    pending_rsp [$];

   int  fail_count = 0;
   int  items_sent = 0;
   int  rsp_seen = 0;
   int  idle_cycles = 0;
   bit  idle_free = 1'b0;      // no random idling on either side
   bit  hold_off = 1'b0;       // receiver held off by the pressure test
   int  act_hits [8];

   // Work out the response of one action and update the table copy.
   function automatic ssrt_pkg::rsp_type model_action(ssrt_pkg::req_type r);
      ssrt_pkg::rsp_type o;
      int          pos;
      longint      start;
      longint      cnt;
      longint      t;
      longint      e;
      o = '0;
      o.status = ssrt_pkg::ST_OK;
      case (r.action)
         ssrt_pkg::ACT_INSERT: begin
            if (tbl_count >= DEPTH) begin
               o.status = ssrt_pkg::ST_FULL;
            end else begin
               pos = 0;
               while (pos < tbl_count && tbl[pos].start <= r.sector) pos++;
               for (int k = tbl_count; k > pos; k--) tbl[k] = tbl[k-1];
               tbl[pos] = '{start: r.sector, length: r.count, id: r.req_id, enabled: 1'b1};
               tbl_count++;
            end
         end
         ssrt_pkg::ACT_FIND: begin
            o.status = ssrt_pkg::ST_NOT_FOUND;
            for (int i = 0; i < tbl_count; i++) begin
               e = longint'(tbl[i].start) + longint'(tbl[i].length);
               if (tbl[i].start <= r.sector && e > longint'(r.sector)) begin
                  o.status        = ssrt_pkg::ST_OK;
                  o.found_id      = tbl[i].id;
                  o.found_enabled = tbl[i].enabled;
                  break;
               end
            end
         end
         ssrt_pkg::ACT_REMOVE: begin
            o.status = ssrt_pkg::ST_NOT_FOUND;
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl[i].id == r.req_id) begin
                  for (int k = i; k + 1 < tbl_count; k++) tbl[k] = tbl[k+1];
                  tbl_count--;
                  o.status = ssrt_pkg::ST_OK;
                  break;
               end
            end
         end
         ssrt_pkg::ACT_CLIP: begin
            start = longint'(r.sector);
            cnt   = (r.count != 0) ? longint'(r.count) : 1;
            if (r.total_sectors == 0) start = 0;
            else if (r.sector >= r.total_sectors) start = longint'(r.total_sectors) - 1;
            for (int i = 0; i < tbl_count && cnt > 0; i++) begin
               if (!tbl[i].enabled) continue;
               t = longint'(tbl[i].start) - start;
               if (t > 0) begin
                  if (t < cnt) cnt = t;
                  break;
               end
               t = longint'(tbl[i].start) + longint'(tbl[i].length);
               if (t > start) begin
                  cnt   = start + cnt - t;
                  start = t;
               end
            end
            if (cnt < 0) cnt = 0;
            if (start > 64'hFFFF_FFFF) begin
               start = 64'hFFFF_FFFF;
               cnt   = 0;
            end
            o.clip_start = start[31:0];
            o.clip_count = cnt[15:0];
         end
         ssrt_pkg::ACT_TRUNCATE: begin
            for (int i = 0; i < tbl_count; i++) begin
               e = longint'(tbl[i].start) + longint'(tbl[i].length);
               if (e > longint'(r.limit_sectors)) begin
                  tbl[i].enabled = 1'b0;
                  o.any_disabled = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic bit idle_roll();
      return !idle_free && ($urandom_range(99) < 19);
   endfunction

   // Offer one request, hold it until the transfer, then record the prediction.
   // Valid stays high afterwards; the next call drops it only for random idling, the end of the run drops it.
   task automatic send_action(ssrt_pkg::req_type r);
      if (idle_roll()) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (idle_roll()) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_rsp.push_back(model_action(r));
      act_hits[r.action]++;
      items_sent++;
   endtask

   function automatic ssrt_pkg::req_type make_req(logic [2:0] act, logic [31:0] sec,
                                                  logic [15:0] cnt, logic [7:0] id,
                                                  logic [31:0] tot, logic [31:0] lim);
      ssrt_pkg::req_type r;
      r = '{action: act, sector: sec, count: cnt, req_id: id, total_sectors: tot,
            limit_sectors: lim};
      return r;
   endfunction

   // Random request; sectors mostly in a narrow window so ranges overlap.
   function automatic ssrt_pkg::req_type rand_req(logic [2:0] act);
      ssrt_pkg::req_type r;
      r.action = act;
      case ($urandom_range(3))
         0:       r.sector = $urandom;
         1:       r.sector = 32'hFFFF_FFFF - $urandom_range(300);
         default: r.sector = $urandom_range(400);
      endcase
      r.count = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(60));
      r.req_id = ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
      case ($urandom_range(3))
         0:       r.total_sectors = $urandom;
         1:       r.total_sectors = $urandom_range(500);
         2:       r.total_sectors = 32'hFFFF_FFFF;
         default: r.total_sectors = 0;
      endcase
      r.limit_sectors = ($urandom_range(2) == 0) ? $urandom : $urandom_range(500);
      return r;
   endfunction

   // Response checker.
   always @(posedge clock) begin
      ssrt_pkg::rsp_type got;
      ssrt_pkg::rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               $error("response with no request outstanding: %p", got);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.found_id !== want.found_id) begin
                  $error("found_id: expected %0d actual %0d", want.found_id, got.found_id);
                  fail_count++;
               end
               if (got.found_enabled !== want.found_enabled) begin
                  $error("found_enabled: expected %0d actual %0d", want.found_enabled,
                         got.found_enabled);
                  fail_count++;
               end
               if (got.clip_start !== want.clip_start) begin
                  $error("clip_start: expected %h actual %h", want.clip_start, got.clip_start);
                  fail_count++;
               end
               if (got.clip_count !== want.clip_count) begin
                  $error("clip_count: expected %0d actual %0d", want.clip_count, got.clip_count);
                  fail_count++;
               end
               if (got.any_disabled !== want.any_disabled) begin
                  $error("any_disabled: expected %0d actual %0d", want.any_disabled,
                         got.any_disabled);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= !hold_off && !idle_roll();
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Extremes of every field plus each named corner.
   task automatic test_directed();
      send_action(make_req(ssrt_pkg::ACT_FIND, 32'd5, 16'd0, 8'd0, 32'd0, 32'd0)); // empty
      send_action(make_req(ssrt_pkg::ACT_REMOVE, 32'd0, 16'd0, 8'd9, 32'd0, 32'd0)); // miss
      send_action(make_req(ssrt_pkg::ACT_INSERT, 32'd100, 16'd10, 8'd1, 32'd0, 32'd0));
      send_action(make_req(ssrt_pkg::ACT_INSERT, 32'd100, 16'd0, 8'd2, 32'd0, 32'd0)); // zero len
      send_action(make_req(ssrt_pkg::ACT_INSERT, 32'd50, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
      send_action(make_req(ssrt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'd3, 32'd0, 32'd0));
      send_action(make_req(ssrt_pkg::ACT_INSERT, 32'hFFFF_FFF0, 16'hFFFF, 8'd4, 32'd0, 32'd0));
      send_action(make_req(ssrt_pkg::ACT_FIND, 32'd100, 16'd0, 8'd0, 32'd0, 32'd0));
      send_action(make_req(ssrt_pkg::ACT_FIND, 32'hFFFF_FFFF, 16'd0, 8'd0, 32'd0, 32'd0));
      send_action(make_req(ssrt_pkg::ACT_CLIP, 32'd40, 16'd0, 8'd0, 32'd1000, 32'd0)); // cnt 0
      send_action(make_req(ssrt_pkg::ACT_CLIP, 32'd60, 16'd20, 8'd0, 32'd0, 32'd0)); // no file
      send_action(make_req(ssrt_pkg::ACT_CLIP, 32'd900, 16'd20, 8'd0, 32'd200, 32'd0)); // clamp
      // start covered by a range ending past the top of the sector space
      send_action(make_req(ssrt_pkg::ACT_CLIP, 32'hFFFF_FFFE, 16'hFFFF, 8'd0, 32'hFFFF_FFFF,
                           32'd0));
      send_action(make_req(ssrt_pkg::ACT_TRUNCATE, 32'd0, 16'd0, 8'd0, 32'd0, 32'd200));
      send_action(make_req(ssrt_pkg::ACT_TRUNCATE, 32'd0, 16'd0, 8'd0, 32'd0, 32'd200)); // off
      send_action(make_req(ssrt_pkg::ACT_FIND, 32'd60, 16'd0, 8'd0, 32'd0, 32'd0)); // disabled
      send_action(make_req(ssrt_pkg::ACT_CLIP, 32'd60, 16'd50, 8'd0, 32'hFFFF_FFFF, 32'd0));
      send_action(make_req(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_action(make_req(3'd6, 32'd1, 16'd1, 8'd1, 32'd1, 32'd1));
      send_action(make_req(3'd7, 32'd0, 16'd0, 8'd0, 32'd0, 32'd0));
      send_action(make_req(ssrt_pkg::ACT_REMOVE, 32'd0, 16'd0, 8'hFF, 32'd0, 32'd0));
      send_action(make_req(ssrt_pkg::ACT_TRUNCATE, 32'd0, 16'd0, 8'd0, 32'd0, 32'hFFFF_FFFF));
   endtask

   // Fill past full, then remove ids 0 to DEPTH + 7 once each.
   task automatic test_full_table();
      for (int i = 0; i < DEPTH + 3; i++)
         send_action(make_req(ssrt_pkg::ACT_INSERT, 32'($urandom_range(300)),
                              16'($urandom_range(40)), 8'(i), 32'd0, 32'd0));
      for (int i = 0; i < DEPTH + 8; i++)
         send_action(make_req(ssrt_pkg::ACT_REMOVE, 32'd0, 16'd0, 8'(i), 32'd0, 32'd0));
   endtask

   // Receiver held off while requests keep being offered.
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 12; i++) send_action(rand_req(3'($urandom_range(4))));
      join
   endtask

   // Random mix; once the table holds more than 12 entries, half the insert picks become removes.
   task automatic test_random(int n, bit no_idle);
      logic [2:0] act;
      idle_free = no_idle;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(19))
            0, 1, 2, 3, 4:
               act = (tbl_count > 12 && $urandom_range(1)) ? ssrt_pkg::ACT_REMOVE :
                                                             ssrt_pkg::ACT_INSERT;
            5, 6, 7, 8:     act = ssrt_pkg::ACT_FIND;
            9, 10, 11:      act = ssrt_pkg::ACT_REMOVE;
            12, 13, 14, 15: act = ssrt_pkg::ACT_CLIP;
            16, 17:         act = ssrt_pkg::ACT_TRUNCATE;
            default:        act = 3'($urandom_range(7));
         endcase
         send_action(rand_req(act));
      end
      idle_free = 1'b0;
   endtask

   initial begin
      int wait_cycles;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      foreach (act_hits[i]) act_hits[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_table();
      test_backpressure();
      test_random(600, 1'b0);
      test_random(150, 1'b1);
      test_random(150, 1'b0);
      req_ch.valid <= 1'b0;

      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4 * (DEPTH + 3)) @(posedge clock);

      $display("covered %0d requests (insert %0d find %0d remove %0d clip %0d truncate %0d)",
               items_sent, act_hits[0], act_hits[1], act_hits[2], act_hits[3], act_hits[4]);
      $display("%0d responses checked, table full and receiver stall included", rsp_seen);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hdl/ssrt_pkg.sv
hdl/ssrt_if.sv
hdl/ssrt_cell.sv
hdl/ssrt_ctrl.sv
hdl/ssrt_remover.sv
hdl/sorted_sector_range_table_top.sv
verif/sorted_sector_range_table_top_tb.sv
